[hw/rtl/foc_pkg.sv]
// ----------------------------------------------------------------------------
// foc_pkg
// Shared constants, types and helpers for the FOC current controller.
// ----------------------------------------------------------------------------
package foc_pkg;

  // angle grid
  localparam int ANGLE_STEPS = 1024;
  localparam int ANGLE_W     = $clog2(ANGLE_STEPS);
  localparam int OFF_B       = (2 * ANGLE_STEPS) / 3;
  localparam int OFF_C       = ANGLE_STEPS / 3;
  localparam int QUARTER     = (3 * ANGLE_STEPS) / 4;

  // datapath widths
  localparam int COS_W   = 12;
  localparam int A_W     = 32;
  localparam int B_W     = 20;
  localparam int DIGIT_W = 4;
  localparam int DIGITS  = B_W / DIGIT_W;
  localparam int ACC_W   = 48;
  localparam int VOLT_W  = 12;
  localparam int ROM_SHIFT  = 20;
  localparam int PARK_SHIFT = 10;

  // register byte addresses
  localparam logic [2:0] ADDR_KI = 3'd0;
  localparam logic [2:0] ADDR_KP = 3'd4;

  // control from sequencer to the MAC unit
  typedef struct packed {
    logic start;
    logic clear;
    logic sub;
  } mac_ctrl_t;

  typedef logic signed [COS_W-1:0] cos_rom_t [ANGLE_STEPS];

  // cosine table, round(1024*cos), half away from zero
  function automatic cos_rom_t cos_table();
    cos_rom_t t;
    real      v;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      v = 1024.0 * $cos(2.0 * 3.14159265358979323846 * i / ANGLE_STEPS);
      if (v >= 0.0) t[i] = COS_W'($rtoi(v + 0.5));
      else          t[i] = COS_W'(-$rtoi(-v + 0.5));
    end
    return t;
  endfunction

  // arithmetic shift by ROM_SHIFT then saturate to the voltage range
  function automatic logic signed [VOLT_W-1:0] sat_volt(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    sh = acc >>> ROM_SHIFT;
    if (sh > ACC_W'(2047))       return VOLT_W'(2047);
    else if (sh < -ACC_W'(2048)) return -VOLT_W'(2048);
    else                         return sh[VOLT_W-1:0];
  endfunction

endpackage

[hw/rtl/foc_current_controller_top.sv]
// ----------------------------------------------------------------------------
// foc_current_controller_top
// Field-oriented current loop: inverse Park, Park and two PI regulators.
// ----------------------------------------------------------------------------
// Input stream (s_*): one request per PWM period. tuser = mode (1 clears
// the regulator integrators and drives and gives no result). A sample
// request first yields three phase voltages from the stored drives at the
// stored angle, then measures d/q currents at the new angle and updates
// both PI regulators.
// Output stream (m_*): one result per sample, volt_a/b/c.
// Config: APB, integral gain at 0x0, proportional gain at 0x4; write only
// while the block is idle.
// Requests are taken one at a time. A sample runs sixteen products through
// one digit-serial MAC (four bits a cycle, five digits); each product passes
// through the address, load and wait states, the cosine ROM being read in
// the address state. The result is registered in the push state, and the next
// request is taken back in idle. A clear request leaves the block idle.
// Reset clears state, gains and the output valid. A stalled result stays in
// the output register; the next request is accepted meanwhile and waits for
// the register only when its own result is ready.
module foc_current_controller_top (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] current_a, [31:16] current_b, [47:32] current_c,
  // [63:48] ref_d, [79:64] ref_q, [89:80] rotor_angle, [95:90] zero
  input  logic [95:0] s_tdata,
  // [0] mode
  input  logic        s_tuser,
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [11:0] volt_a, [23:12] volt_b, [35:24] volt_c, [39:36] zero
  output logic [39:0] m_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam foc_pkg::cos_rom_t COS_ROM = foc_pkg::cos_table();

  typedef enum logic [2:0] {S_IDLE, S_ADDR, S_LOAD, S_WAIT, S_PUSH} state_t;

  state_t state;
  logic [3:0] step;

  // configuration
  logic signed [15:0] ki, kp;
  // regulator state
  logic signed [31:0] integ_d, integ_q, drive_d, drive_q;
  logic [foc_pkg::ANGLE_W-1:0] stored_angle, th;
  // latched request
  logic signed [15:0] cur_a, cur_b, cur_c, ref_d, ref_q;
  logic signed [foc_pkg::B_W-1:0] err_d, err_q;
  logic signed [foc_pkg::VOLT_W-1:0] va, vb, vc;

  // ROM
  logic [foc_pkg::ANGLE_W-1:0]     rom_addr;
  logic signed [foc_pkg::COS_W-1:0] rom_q;

  // MAC
  foc_pkg::mac_ctrl_t               mctl;
  logic signed [foc_pkg::A_W-1:0]   ma;
  logic signed [foc_pkg::B_W-1:0]   mb;
  logic signed [foc_pkg::ACC_W-1:0] acc;
  logic                             mdone;
  logic signed [foc_pkg::ACC_W-1:0] park;

  logic [foc_pkg::ANGLE_W-1:0] base, offs;
  logic quarter;

  assign pready   = 1'b1;
  assign s_tready = (state == S_IDLE);
  assign prdata   = (paddr == foc_pkg::ADDR_KI) ? {{16{ki[15]}}, ki} :
                    (paddr == foc_pkg::ADDR_KP) ? {{16{kp[15]}}, kp} : 32'd0;
  assign park     = acc >>> foc_pkg::PARK_SHIFT;

  // angle of the product in hand
  always_comb begin
    base    = (step < 4'd6) ? stored_angle : th;
    quarter = 1'b0;
    offs    = '0;
    case (step)
      4'd1:  quarter = 1'b1;
      4'd2:  offs = foc_pkg::ANGLE_W'(foc_pkg::OFF_B);
      4'd3:  begin offs = foc_pkg::ANGLE_W'(foc_pkg::OFF_B); quarter = 1'b1; end
      4'd4:  offs = foc_pkg::ANGLE_W'(foc_pkg::OFF_C);
      4'd5:  begin offs = foc_pkg::ANGLE_W'(foc_pkg::OFF_C); quarter = 1'b1; end
      4'd7:  offs = foc_pkg::ANGLE_W'(foc_pkg::OFF_B);
      4'd8:  offs = foc_pkg::ANGLE_W'(foc_pkg::OFF_C);
      4'd9:  quarter = 1'b1;
      4'd10: begin offs = foc_pkg::ANGLE_W'(foc_pkg::OFF_B); quarter = 1'b1; end
      4'd11: begin offs = foc_pkg::ANGLE_W'(foc_pkg::OFF_C); quarter = 1'b1; end
      default: ;
    endcase
    // wraps modulo the angle grid
    rom_addr = base + offs + (quarter ? foc_pkg::ANGLE_W'(foc_pkg::QUARTER) : '0);
  end

  always_ff @(posedge clk) begin
    rom_q <= COS_ROM[rom_addr];
  end

  // operand selection and MAC control per step
  always_comb begin
    mctl.start = (state == S_LOAD);
    mctl.clear = 1'b0;
    mctl.sub   = 1'b0;
    mb = foc_pkg::B_W'(rom_q);
    ma = '0;
    case (step)
      4'd0, 4'd2, 4'd4: begin ma = drive_d; mctl.clear = 1'b1; end
      4'd1, 4'd3, 4'd5: begin ma = drive_q; mctl.sub = 1'b1; end
      4'd6:  begin ma = 32'(cur_a); mctl.clear = 1'b1; end
      4'd7:  ma = 32'(cur_b);
      4'd8:  ma = 32'(cur_c);
      4'd9:  begin ma = 32'(cur_a); mctl.clear = 1'b1; mctl.sub = 1'b1; end
      4'd10: begin ma = 32'(cur_b); mctl.sub = 1'b1; end
      4'd11: begin ma = 32'(cur_c); mctl.sub = 1'b1; end
      4'd12: begin ma = 32'(ki); mb = err_d; mctl.clear = 1'b1; end
      4'd13: begin ma = 32'(kp); mb = err_d; mctl.clear = 1'b1; end
      4'd14: begin ma = 32'(ki); mb = err_q; mctl.clear = 1'b1; end
      4'd15: begin ma = 32'(kp); mb = err_q; mctl.clear = 1'b1; end
      default: ;
    endcase
  end

  foc_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mctl),
    .a    (ma),
    .b    (mb),
    .acc  (acc),
    .done (mdone)
  );

  // sequencer, regulator state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      ki           <= '0;
      kp           <= '0;
      integ_d      <= '0;
      integ_q      <= '0;
      drive_d      <= '0;
      drive_q      <= '0;
      stored_angle <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // S_PUSH reloads the register itself
      if (m_tvalid && m_tready && (state != S_PUSH)) m_tvalid <= 1'b0;

      // register writes
      if (psel && penable && pwrite && pready) begin
        unique case (paddr)
          foc_pkg::ADDR_KI: ki <= pwdata[15:0];
          foc_pkg::ADDR_KP: kp <= pwdata[15:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cur_a <= s_tdata[15:0];
            cur_b <= s_tdata[31:16];
            cur_c <= s_tdata[47:32];
            ref_d <= s_tdata[63:48];
            ref_q <= s_tdata[79:64];
            th    <= s_tdata[80 +: foc_pkg::ANGLE_W];
            step  <= '0;
            if (s_tuser) begin
              integ_d <= '0;
              integ_q <= '0;
              drive_d <= '0;
              drive_q <= '0;
            end else begin
              state <= S_ADDR;
            end
          end
        end
        S_ADDR: state <= S_LOAD;
        S_LOAD: state <= S_WAIT;
        S_WAIT: begin
          if (mdone) begin
            case (step)
              4'd1:  va <= foc_pkg::sat_volt(acc);
              4'd3:  vb <= foc_pkg::sat_volt(acc);
              4'd5:  vc <= foc_pkg::sat_volt(acc);
              4'd8:  err_d <= foc_pkg::B_W'(ref_d) - park[foc_pkg::B_W-1:0];
              4'd11: err_q <= foc_pkg::B_W'(ref_q) - park[foc_pkg::B_W-1:0];
              4'd12: integ_d <= integ_d + acc[31:0];
              4'd13: drive_d <= integ_d + acc[31:0];
              4'd14: integ_q <= integ_q + acc[31:0];
              4'd15: drive_q <= integ_q + acc[31:0];
              default: ;
            endcase
            step  <= step + 1'b1;
            state <= (step == 4'd15) ? S_PUSH : S_ADDR;
          end
        end
        S_PUSH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata      <= {4'd0, vc, vb, va};
            m_tvalid     <= 1'b1;
            stored_angle <= th;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/foc_mac.sv]
// ----------------------------------------------------------------------------
// foc_mac
// Digit-serial multiply-accumulate: acc (+/-)= a * b, four bits of b a cycle.
// ----------------------------------------------------------------------------
module foc_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  foc_pkg::mac_ctrl_t                    ctrl,
  input  logic signed [foc_pkg::A_W-1:0]        a,
  input  logic signed [foc_pkg::B_W-1:0]        b,
  output logic signed [foc_pkg::ACC_W-1:0]      acc,
  output logic                                  done
);

  localparam int CNT_W = $clog2(foc_pkg::DIGITS);

  logic signed [foc_pkg::ACC_W-1:0]   a_sh;
  logic signed [foc_pkg::B_W-1:0]     b_sh;
  logic [CNT_W-1:0]                   cnt;
  logic                               busy;
  logic                               sub;
  logic signed [foc_pkg::DIGIT_W:0]   dig;
  logic signed [foc_pkg::ACC_W+foc_pkg::DIGIT_W:0] prod;
  logic                               last;

  // top digit carries the sign of b
  assign last = (cnt == CNT_W'(foc_pkg::DIGITS - 1));
  assign dig  = last ? {b_sh[foc_pkg::DIGIT_W-1], b_sh[foc_pkg::DIGIT_W-1:0]}
                     : {1'b0, b_sh[foc_pkg::DIGIT_W-1:0]};
  assign prod = a_sh * dig;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      acc  <= '0;
    end else begin
      done <= busy && last;
      if (ctrl.start) begin
        a_sh <= foc_pkg::ACC_W'(a);
        b_sh <= b;
        sub  <= ctrl.sub;
        cnt  <= '0;
        busy <= 1'b1;
        if (ctrl.clear) acc <= '0;
      end else if (busy) begin
        // one digit partial product per cycle
        if (sub) acc <= acc - prod[foc_pkg::ACC_W-1:0];
        else     acc <= acc + prod[foc_pkg::ACC_W-1:0];
        a_sh <= a_sh <<< foc_pkg::DIGIT_W;
        b_sh <= b_sh >>> foc_pkg::DIGIT_W;
        cnt  <= cnt + 1'b1;
        if (last) busy <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/foc_checker.sv]
// ----------------------------------------------------------------------------
// foc_checker
// Port-level checks on the FOC current controller, bound to the top level.
// ----------------------------------------------------------------------------
module foc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // a clear request never yields a result
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !$rose(m_tvalid))
    else $error("clear request produced a result");

  // a sample request keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> !s_tready)
    else $error("request taken while a sample is in work");

endmodule

bind foc_current_controller_top foc_checker u_foc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
